// ===== hdl/pol_pkg.sv =====
// Shared types and constants for the positional ordered list.
// No dependencies; used by pol_store and positional_ordered_list.
package pol_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned PosW        = 5;
  localparam int unsigned LenW        = 5;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_POS   = 3'd5,
    CMD_READ      = 3'd6
  } pol_cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } pol_status_e;

  // Shift request to the entry row
  typedef struct packed {
    logic ins;
    logic del;
  } pol_op_t;

endpackage

// ===== hdl/pol_store.sv =====
// Ordered list entry row: cells at or past the shift point move one place.
// Depends on pol_pkg.
module pol_store #(
  parameter int unsigned Capacity = pol_pkg::DefCapacity
) (
  input  logic                                clk_i,
  input  pol_pkg::pol_op_t                    op_i,
  input  logic [$clog2(Capacity)-1:0]         idx_i,
  input  logic signed [pol_pkg::ValueW-1:0]   data_i,
  output logic signed [pol_pkg::ValueW-1:0]   rd_data_o
);
  import pol_pkg::*;

  localparam int unsigned IdxW = $clog2(Capacity);

  logic signed [ValueW-1:0] entry_q [Capacity];

  // single read port, same index as the shift point
  assign rd_data_o = entry_q[idx_i];

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    localparam logic [IdxW-1:0] Here = IdxW'(i);
    logic                     en;
    logic signed [ValueW-1:0] entry_d;

    always_comb begin
      en      = 1'b0;
      entry_d = entry_q[i];
      if (op_i.ins) begin
        if (Here == idx_i) begin
          en      = 1'b1;
          entry_d = data_i;
        end else if (Here > idx_i) begin
          en      = 1'b1;
          entry_d = entry_q[(i > 0) ? i - 1 : 0];
        end
      end else if (op_i.del) begin
        if (Here >= idx_i && i < Capacity - 1) begin
          en      = 1'b1;
          entry_d = entry_q[(i < Capacity - 1) ? i + 1 : i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        entry_q[i] <= entry_d;
      end
    end
  end

endmodule

// ===== hdl/positional_ordered_list.sv =====
// Top level of the positional ordered list.
// Depends on pol_pkg and pol_store.

// Bounded ordered list of up to CAPACITY signed 32-bit values. Each input
// word carries one command: insert at front, back or a 1-based position,
// delete at front, back or a position, or read at a position. Every command
// yields exactly one result word with a status (ok, full, empty, position
// out of range), the value read or removed (zero otherwise) and the list
// length after the command, reported in 5 bits. Refused commands and the
// unused command code leave the list unchanged. Throughput is one command
// per cycle: entries from the shift point on shift one place in one pass,
// and the result is registered in an output register on acceptance. That
// register decouples the sides, so a new command is taken whenever the
// output register is empty or its word is being taken in the same cycle.
module positional_ordered_list #(
  parameter int unsigned CAPACITY = pol_pkg::DefCapacity
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        command_i,
  input  logic signed [pol_pkg::ValueW-1:0] item_value_i,
  input  logic [pol_pkg::PosW-1:0]          position_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic signed [pol_pkg::ValueW-1:0] result_value_o,
  output logic [pol_pkg::LenW-1:0]          list_length_o
);
  import pol_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  // common width for position / count compares
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

  // list occupancy
  logic [CntW-1:0] count_q, count_d;

  // result register
  logic                     out_valid_q;
  pol_status_e              status_q;
  logic signed [ValueW-1:0] value_q;
  logic [LenW-1:0]          len_q;

  logic                     accept;
  logic                     full, empty;
  logic [CmpW-1:0]          pos_w, cnt_w, idx_w;
  pol_status_e              status_d;
  logic                     take;
  pol_op_t                  op;
  logic signed [ValueW-1:0] rd_data;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign full  = (count_q == CntW'(CAPACITY));
  assign empty = (count_q == '0);
  assign pos_w = CmpW'(position_i);
  assign cnt_w = CmpW'(count_q);

  // Decode: status, shift point and shift direction
  always_comb begin
    status_d = ST_OK;
    op       = '0;
    take     = 1'b0;
    idx_w    = '0;
    case (pol_cmd_e'(command_i))
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (pol_cmd_e'(command_i) == CMD_INS_FRONT) begin
          op.ins = 1'b1;
        end else if (pol_cmd_e'(command_i) == CMD_INS_BACK) begin
          op.ins = 1'b1;
          idx_w  = cnt_w;
        end else if (pos_w == '0 || pos_w > cnt_w + CmpW'(1)) begin
          status_d = ST_RANGE;
        end else begin
          op.ins = 1'b1;
          idx_w  = pos_w - CmpW'(1);
        end
      end
      CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS, CMD_READ: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (pol_cmd_e'(command_i) == CMD_DEL_FRONT) begin
          op.del = 1'b1;
          take   = 1'b1;
        end else if (pol_cmd_e'(command_i) == CMD_DEL_BACK) begin
          op.del = 1'b1;
          take   = 1'b1;
          idx_w  = cnt_w - CmpW'(1);
        end else if (pos_w == '0 || pos_w > cnt_w) begin
          status_d = ST_RANGE;
        end else begin
          take   = 1'b1;
          op.del = (pol_cmd_e'(command_i) == CMD_DEL_POS);
          idx_w  = pos_w - CmpW'(1);
        end
      end
      default: begin
        // unused code: no change, ok status
      end
    endcase
    if (!accept) begin
      op = '0;
    end
  end

  always_comb begin
    count_d = count_q;
    if (op.ins) begin
      count_d = count_q + CntW'(1);
    end else if (op.del) begin
      count_d = count_q - CntW'(1);
    end
  end

  pol_store #(
    .Capacity(CAPACITY)
  ) u_store (
    .clk_i    (clk_i),
    .op_i     (op),
    .idx_i    (idx_w[IdxW-1:0]),
    .data_i   (item_value_i),
    .rd_data_o(rd_data)
  );

  logic [CmpW-1:0] len_w;
  assign len_w = CmpW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      value_q  <= take ? rd_data : '0;
      len_q    <= len_w[LenW-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign result_value_o = value_q;
  assign list_length_o  = len_q;

endmodule

// ===== verif/tb_positional_ordered_list.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for positional_ordered_list: directed corner words, then
// biased random command streams. Depends on pol_pkg and the RTL under hdl/.
module tb_positional_ordered_list;
  import pol_pkg::*;

  localparam int unsigned Capacity   = DefCapacity;
  localparam int unsigned StallLimit = 2000;  // cycles with no word moving on either side
  localparam int unsigned RandWords  = 1920;
  localparam logic [2:0]  CmdUnused  = 3'd7;  // spare opcode, must be a no-op

  typedef struct {
    pol_status_e        status;
    logic signed [31:0] value;
    logic [4:0]         length;
  } list_result_t;

  // Shadow copy of the list. Each accepted command word is applied here and
  // its result queued; results leave the block in command order.
  class list_scoreboard;
    logic signed [31:0] row [Capacity];
    int unsigned        count;
    list_result_t       pending [$];
    int unsigned        errors;

    function void note_command(logic [2:0] cmd, logic signed [31:0] val, logic [4:0] pos);
      list_result_t r;
      int unsigned  idx;
      r.status = ST_OK;
      r.value  = '0;
      case (cmd)
        CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
          // full wins over a bad position
          if (count >= Capacity) begin
            r.status = ST_FULL;
          end else if (cmd == CMD_INS_POS && (pos == 0 || pos > count + 1)) begin
            r.status = ST_RANGE;
          end else begin
            idx = (cmd == CMD_INS_FRONT) ? 0 : (cmd == CMD_INS_BACK) ? count : pos - 1;
            for (int i = count; i > idx; i--) row[i] = row[i-1];
            row[idx] = val;
            count++;
          end
        end
        CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS, CMD_READ: begin
          // empty wins over a bad position
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else if ((cmd == CMD_DEL_POS || cmd == CMD_READ) && (pos == 0 || pos > count)) begin
            r.status = ST_RANGE;
          end else begin
            idx = (cmd == CMD_DEL_FRONT) ? 0 : (cmd == CMD_DEL_BACK) ? count - 1 : pos - 1;
            r.value = row[idx];
            if (cmd != CMD_READ) begin
              for (int i = idx; i + 1 < count; i++) row[i] = row[i+1];
              count--;
            end
          end
        end
        default: ;
      endcase
      r.length = count[4:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic signed [31:0] val, logic [4:0] len);
      list_result_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: status %0d value %0d length %0d",
                 $time, st, val, len);
        return;
      end
      e = pending.pop_front();
      if (st !== e.status || val !== e.value || len !== e.length) begin
        errors++;
        $display("%0t: mismatch: expected status %0d value %0d length %0d, got %0d %0d %0d",
                 $time, e.status, e.value, e.length, st, val, len);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic [2:0]         command_i      = '0;
  logic signed [31:0] item_value_i   = '0;
  logic [4:0]         position_i     = '0;
  logic               out_ready_i    = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [1:0]         status_o;
  logic signed [31:0] result_value_o;
  logic [4:0]         list_length_o;

  list_scoreboard sb = new();

  // Knobs set by the stimulus thread; calm and hold_cycles also steer the result-side thread.
  bit growing;             // random stream bias: toward full or toward empty
  bit calm;                // no idling on either side while set
  int unsigned hold_cycles;  // long back-pressure request for the receiver

  wire in_taken  = in_valid_i && in_ready_o;
  wire out_taken = out_valid_o && out_ready_i;

  positional_ordered_list #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .item_value_i  (item_value_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .result_value_o(result_value_o),
    .list_length_o (list_length_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Everything is driven at the rising edge, so the falling edge sees exactly
  // what the next rising edge will take: handshakes are judged there.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) sb.check_result(status_o, result_value_o, list_length_o);
      if (in_taken)  sb.note_command(command_i, item_value_i, position_i);
    end
  end

  // Mostly short gaps, occasionally a long one.
  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // Result side: random stalls, plus a long hold-off when asked for.
  initial begin : receiver
    int unsigned stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else if (calm || $urandom_range(99) < 65) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        stall = gap_length();
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(negedge clk_i);
      if (in_taken || out_taken) quiet = 0;
      else quiet++;
    end
    $display("FAIL positional_ordered_list");
    $finish;
  end

  // Called at a rising edge; returns at the rising edge that takes the word.
  // Valid is only dropped when a gap is inserted, so back-to-back words keep
  // it high without a second assignment in the same step.
  task automatic send_word(input logic [2:0] cmd, input logic signed [31:0] val,
                           input logic [4:0] pos);
    int unsigned n;
    n = gap_length();
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    item_value_i <= val;
    position_i   <= pos;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    // empty list: every removal/read refused, empty beats a bad position
    send_word(CMD_DEL_FRONT, 32'sd5, 5'd1);
    send_word(CMD_DEL_BACK,  32'sd5, 5'd1);
    send_word(CMD_DEL_POS,   32'sd5, 5'd0);
    send_word(CMD_READ,      32'sd5, 5'd31);
    // positional insert bounds on an empty list
    send_word(CMD_INS_POS, 32'sd9, 5'd0);
    send_word(CMD_INS_POS, 32'sd9, 5'd2);
    send_word(CMD_INS_POS, 32'sh8000_0000, 5'd1);
    send_word(CMD_INS_FRONT, 32'sh7fff_ffff, 5'd0);
    send_word(CMD_INS_BACK, 32'sd0, 5'd0);
    send_word(CMD_INS_POS, -32'sd1, 5'd4);        // one past the tail
    send_word(CMD_READ, 32'sd0, 5'd0);
    send_word(CMD_READ, 32'sd0, 5'd5);
    send_word(CMD_READ, 32'sd0, 5'd4);
    send_word(CMD_DEL_POS, 32'sd0, 5'd31);
    send_word(CmdUnused, -32'sd1, 5'd31);
    send_word(CMD_DEL_POS, 32'sd0, 5'd2);
    // fill to capacity, then full beats a bad position
    while (sb.count < Capacity) send_word(CMD_INS_BACK, $urandom, 5'd0);
    send_word(CMD_INS_FRONT, 32'sd1, 5'd0);
    send_word(CMD_INS_BACK, 32'sd1, 5'd0);
    send_word(CMD_INS_POS, 32'sd1, 5'd31);
    send_word(CMD_READ, 32'sd0, Capacity[4:0]);
    send_word(CMD_DEL_POS, 32'sd0, Capacity[4:0]);
    send_word(CMD_DEL_BACK, 32'sd0, 5'd0);
    send_word(CMD_DEL_FRONT, 32'sd0, 5'd0);
  endtask

  // Random word biased so the list swings between empty and full; positions
  // mostly land inside the live range, with edges and noise mixed in.
  task automatic pick_word(output logic [2:0] cmd, output logic signed [31:0] val,
                           output logic [4:0] pos);
    int unsigned r;
    int unsigned n;
    int unsigned lim;
    bit          ins;
    n = sb.count;
    if (n >= Capacity) growing = 1'b0;
    else if (n == 0) growing = 1'b1;
    else if ($urandom_range(39) == 0) growing = !growing;
    r   = $urandom_range(99);
    ins = growing ? (r < 67) : (r < 35);
    if (r < 2) begin
      cmd = CmdUnused;
    end else if (ins) begin
      case ($urandom_range(2))
        0:       cmd = CMD_INS_FRONT;
        1:       cmd = CMD_INS_BACK;
        default: cmd = CMD_INS_POS;
      endcase
    end else begin
      case ($urandom_range(4))
        0:       cmd = CMD_DEL_FRONT;
        1:       cmd = CMD_DEL_BACK;
        2:       cmd = CMD_DEL_POS;
        default: cmd = CMD_READ;
      endcase
    end
    lim = ins ? n + 1 : n;
    if (lim == 0) lim = 1;
    r = $urandom_range(99);
    if (r < 85)      pos = 5'($urandom_range(lim, 1));
    else if (r < 92) pos = '0;
    else if (r < 96) pos = 5'(lim + 1);
    else             pos = 5'($urandom_range(31));
    case ($urandom_range(9))
      0:       val = 32'sh8000_0000;
      1:       val = 32'sh7fff_ffff;
      2:       val = -32'sd1;
      default: val = $urandom;
    endcase
  endtask

  initial begin : stimulus
    logic [2:0]         cmd;
    logic signed [31:0] val;
    logic [4:0]         pos;
    int unsigned        sent;
    growing     = 1'b1;
    calm        = 1'b0;
    hold_cycles = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    sent = 0;
    while (sent < RandWords) begin
      // long receiver hold-off while words keep coming: output stage fills,
      // input side must stall
      if (sent == 400 || sent == 1500) hold_cycles = 120;
      // sender stops and waits for every outstanding result
      if (sent == 900) drain_results();
      calm = (sent >= 1100 && sent < 1300);
      pick_word(cmd, val, pos);
      send_word(cmd, val, pos);
      if (cmd != CmdUnused) sent++;
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS positional_ordered_list");
    end else begin
      $display("FAIL positional_ordered_list");
    end
    $finish;
  end

endmodule
